[rtl/hdtb_pkg.sv]
// ----------------------------------------------------------------------------
// hdtb_pkg
// Shared types and constants for the canonical Huffman decode table builder.
// ----------------------------------------------------------------------------
package hdtb_pkg;

  localparam int MAX_LEN_DEF = 12;
  localparam int SYM_W       = 32;
  localparam int LEN_W       = 4;
  localparam int WIN_W       = 12;
  localparam int STAT_W      = 2;
  localparam int ENTRY_W     = SYM_W + LEN_W;

  localparam logic [LEN_W-1:0] CFG_LEN_RESET = LEN_W'(12);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_LEN  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_READ = 3'b100
  } state_t;

  typedef struct packed {
    logic              load;
    logic [STAT_W-1:0] status;
    logic              use_ram;
    logic              complete;
  } res_t;

endpackage

[rtl/hdtb_ram.sv]
// ----------------------------------------------------------------------------
// hdtb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hdtb_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/hdtb_ctrl.sv]
// ----------------------------------------------------------------------------
// hdtb_ctrl
// Sequencer that checks each beat, fills table entries one per cycle through
// an address incrementer, and issues lookup reads.
// ----------------------------------------------------------------------------
module hdtb_ctrl import hdtb_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [LEN_W-1:0]   code_length,
  input  logic               last_symbol,
  input  logic [WIN_W-1:0]   window_bits,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_len,
  output logic               idle,
  output res_t               res,
  output logic               ram_we,
  output logic [MAX_LEN-1:0] ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [MAX_LEN-1:0] ram_raddr
);

  localparam int PW = MAX_LEN + 1;
  localparam int XW = (WIN_W > PW) ? WIN_W : PW;

  state_t           state;
  logic [PW-1:0]    fill_pointer;
  logic             complete;
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rem;
  logic [SYM_W-1:0] sym_q;
  logic [LEN_W-1:0] len_q;
  logic             last_q;

  logic [LEN_W-1:0] eff_len;
  logic [PW-1:0]    size;
  logic [PW-1:0]    times;
  logic             bad_len;
  logic             overflow;
  logic [XW-1:0]    idx;
  logic             hit;

  always_comb begin
    if (cfg_len == '0) begin
      eff_len = LEN_W'(1);
    end else if ({1'b0, cfg_len} > (LEN_W + 1)'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = cfg_len;
    end
  end

  assign size     = PW'(1) << eff_len;
  assign bad_len  = (code_length == '0) || (code_length > eff_len);
  assign times    = PW'(1) << (eff_len - code_length);
  assign overflow = ((PW + 1)'(fill_pointer) + (PW + 1)'(times)) > (PW + 1)'(size);
  assign idx      = XW'(window_bits) & (XW'(size) - XW'(1));
  assign hit      = idx < XW'(fill_pointer);

  assign idle      = (state == ST_IDLE);
  assign ram_re    = start && (func == FUNC_LOOKUP) && hit;
  assign ram_raddr = idx[MAX_LEN-1:0];
  assign ram_we    = (state == ST_FILL);
  assign ram_waddr = wp[MAX_LEN-1:0];
  assign ram_wdata = {sym_q, len_q};

  always_comb begin
    res.load     = 1'b0;
    res.status   = STAT_OK;
    res.use_ram  = 1'b0;
    res.complete = complete;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_INSERT) begin
            if (bad_len) begin
              res.load   = 1'b1;
              res.status = STAT_BAD_LEN;
            end else if (overflow) begin
              res.load   = 1'b1;
              res.status = STAT_OVERFLOW;
            end
          end else if (!hit) begin
            res.load   = 1'b1;
            res.status = STAT_MISS;
          end
        end
      end
      ST_READ: begin
        res.load    = 1'b1;
        res.use_ram = 1'b1;
      end
      ST_FILL: begin
        if (rem == '0) begin
          res.load     = 1'b1;
          res.complete = complete | last_q;
        end
      end
      default: begin
        res.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_pointer <= '0;
      complete     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_we) begin
            fill_pointer <= '0;
            complete     <= 1'b0;
          end else if (start) begin
            if (func == FUNC_LOOKUP) begin
              if (hit) begin
                state <= ST_READ;
              end
            end else if (!bad_len && !overflow) begin
              state <= ST_FILL;
            end
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_FILL: begin
          if (rem == '0) begin
            fill_pointer <= wp + PW'(1);
            complete     <= complete | last_q;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      wp     <= fill_pointer;
      rem    <= times - PW'(1);
      sym_q  <= symbol;
      len_q  <= code_length;
      last_q <= last_symbol;
    end else if (state == ST_FILL) begin
      wp  <= wp + PW'(1);
      rem <= rem - PW'(1);
    end
  end

endmodule

[rtl/huffman_decode_table_builder.sv]
// ----------------------------------------------------------------------------
// huffman_decode_table_builder
// Builds a flat canonical Huffman decode table and answers window lookups.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  in        input      in_valid/in_ready  func, symbol, code_length,
//                                          last_symbol, window_bits
//  out       output     out_valid/out_ready status, found_symbol,
//                                          found_length, table_complete
//  cfg       input      cfg_we             cfg_data
//
// A lookup beat makes one table read when it hits and none when it misses.
// An insert beat writes 2^(L-n) entries, one table write per entry; rejected
// inserts write no entry.
// Reset clears the fill pointer and complete flag; the table is not cleared.
// The input is not ready while a beat is in work or a result waits unread.
module huffman_decode_table_builder import hdtb_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic signed [SYM_W-1:0] symbol,
  input  logic [LEN_W-1:0]        code_length,
  input  logic                    last_symbol,
  input  logic [WIN_W-1:0]        window_bits,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       status,
  output logic signed [SYM_W-1:0] found_symbol,
  output logic [LEN_W-1:0]        found_length,
  output logic                    table_complete,
  input  logic                    cfg_we,
  input  logic [LEN_W-1:0]        cfg_data
);

  logic [LEN_W-1:0]   cfg_len;
  logic               idle;
  logic               start;
  res_t               res;
  logic               ram_we;
  logic [MAX_LEN-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [MAX_LEN-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_ready = idle && (!out_valid || out_ready);
  assign start    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= CFG_LEN_RESET;
    end else if (cfg_we) begin
      cfg_len <= cfg_data;
    end
  end

  hdtb_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .symbol     (symbol),
    .code_length(code_length),
    .last_symbol(last_symbol),
    .window_bits(window_bits),
    .cfg_we     (cfg_we),
    .cfg_len    (cfg_len),
    .idle       (idle),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  hdtb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(1 << MAX_LEN)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status         <= res.status;
      table_complete <= res.complete;
      if (res.use_ram) begin
        found_symbol <= ram_rdata[ENTRY_W-1:LEN_W];
        found_length <= ram_rdata[LEN_W-1:0];
      end else begin
        found_symbol <= '0;
        found_length <= '0;
      end
    end
  end

endmodule
